// ===== rtl/core/mlfd_pkg.sv =====
`default_nettype none

package mlfd_pkg;

   localparam int BYTE_W    = 8;
   localparam int IDX_W     = 6;
   localparam int CSR_IDX_W = 2;

   // Register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_START_MARKER = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_END_MARKER   = 2'd1;

   // Header bytes of the frame being parsed or replayed
   typedef struct packed {
      logic [BYTE_W-1:0] flag;
      logic [BYTE_W-1:0] id;
      logic [BYTE_W-1:0] length;
   } frame_hdr_type;

   // One result item
   typedef struct packed {
      logic [BYTE_W-1:0] frame_flag;
      logic [BYTE_W-1:0] frame_id;
      logic [BYTE_W-1:0] payload_length;
      logic [IDX_W-1:0]  byte_index;
      logic [BYTE_W-1:0] payload_byte;
      logic              empty_payload;
      logic              truncated;
      logic              last;
   } rsp_item_type;

endpackage

`default_nettype wire

// ===== rtl/core/mlfd_buffer.sv =====
`default_nettype none

module mlfd_buffer import mlfd_pkg::*; #(
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [AW-1:0]     wr_addr,
   input  wire logic [BYTE_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [AW-1:0]     rd_addr,
   output logic      [BYTE_W-1:0] rd_data
);

   logic [BYTE_W-1:0] mem_ff [0:DEPTH-1];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/mlfd_parser.sv =====
`default_nettype none

module mlfd_parser import mlfd_pkg::*; #(
   parameter int MAX_PAYLOAD = 32,
   parameter int AW          = 5
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [BYTE_W-1:0] rx_byte,
   input  wire logic [BYTE_W-1:0] start_marker,
   input  wire logic [BYTE_W-1:0] end_marker,
   output frame_hdr_type          hdr,
   output logic                   wr_en,
   output logic      [AW-1:0]     wr_addr,
   output logic      [BYTE_W-1:0] wr_data,
   output logic                   replay_start
);

   localparam logic [BYTE_W-1:0] STORE_DEPTH = BYTE_W'(MAX_PAYLOAD);

   typedef enum logic [5:0] {
      PH_HUNT = 6'b000001,
      PH_FLAG = 6'b000010,
      PH_ID   = 6'b000100,
      PH_LEN  = 6'b001000,
      PH_DATA = 6'b010000,
      PH_TAIL = 6'b100000
   } phase_type;

   phase_type         phase_ff, phase_in;
   frame_hdr_type     hdr_ff, hdr_in;
   logic [BYTE_W-1:0] count_ff, count_in;

   always_comb begin
      phase_in     = phase_ff;
      hdr_in       = hdr_ff;
      count_in     = count_ff;
      wr_en        = 1'b0;
      replay_start = 1'b0;
      if (accept) begin
         unique case (phase_ff)
            PH_FLAG: begin
               hdr_in.flag = rx_byte;
               phase_in    = PH_ID;
            end
            PH_ID: begin
               hdr_in.id = rx_byte;
               phase_in  = PH_LEN;
            end
            PH_LEN: begin
               hdr_in.length = rx_byte;
               count_in      = '0;
               phase_in      = (rx_byte == '0) ? PH_TAIL : PH_DATA;
            end
            PH_DATA: begin
               // drop bytes past the end of the buffer
               wr_en    = (count_ff < STORE_DEPTH);
               count_in = count_ff + 1'b1;
               if (count_in >= hdr_ff.length) begin
                  phase_in = PH_TAIL;
               end
            end
            PH_TAIL: begin
               if (rx_byte == end_marker) begin
                  phase_in     = PH_HUNT;
                  replay_start = 1'b1;
               end
            end
            default: begin
               phase_in = (rx_byte == start_marker) ? PH_FLAG : PH_HUNT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HUNT;
         hdr_ff.flag   <= BYTE_W'(1);
         hdr_ff.id     <= BYTE_W'(1);
         hdr_ff.length <= '0;
         count_ff      <= '0;
      end else begin
         phase_ff <= phase_in;
         hdr_ff   <= hdr_in;
         count_ff <= count_in;
      end
   end

   assign hdr     = hdr_ff;
   assign wr_addr = count_ff[AW-1:0];
   assign wr_data = rx_byte;

endmodule

`default_nettype wire

// ===== rtl/core/mlfd_replay.sv =====
`default_nettype none

module mlfd_replay import mlfd_pkg::*; #(
   parameter int MAX_PAYLOAD = 32,
   parameter int AW          = 5
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  frame_hdr_type          hdr,
   input  wire logic [BYTE_W-1:0] rd_data,
   output logic                   rd_en,
   output logic      [AW-1:0]     rd_addr,
   output logic                   busy,
   output rsp_item_type           rsp,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready
);

   localparam logic [BYTE_W-1:0] STORE_DEPTH = BYTE_W'(MAX_PAYLOAD);
   localparam logic [IDX_W-1:0]  LAST_FULL   = IDX_W'(MAX_PAYLOAD - 1);

   typedef enum logic [2:0] {
      RP_IDLE = 3'b001,
      RP_READ = 3'b010,
      RP_LOAD = 3'b100
   } replay_state_type;

   replay_state_type state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] last_ff, last_in;
   logic             empty_ff, empty_in;
   logic             trunc_ff, trunc_in;
   rsp_item_type     rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             load;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      last_in      = last_ff;
      empty_in     = empty_ff;
      trunc_in     = trunc_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      load         = (state_ff == RP_LOAD) && (!rsp_valid_ff || rsp_ready);

      if (load) begin
         rsp_valid_in          = 1'b1;
         rsp_in.frame_flag     = hdr.flag;
         rsp_in.frame_id       = hdr.id;
         rsp_in.payload_length = hdr.length;
         rsp_in.byte_index     = idx_ff;
         rsp_in.payload_byte   = empty_ff ? '0 : rd_data;
         rsp_in.empty_payload  = empty_ff;
         rsp_in.truncated      = trunc_ff;
         rsp_in.last           = (idx_ff == last_ff);
      end

      unique case (state_ff)
         RP_IDLE: begin
            if (start) begin
               state_in = RP_READ;
               idx_in   = '0;
               empty_in = (hdr.length == '0);
               trunc_in = (hdr.length > STORE_DEPTH);
               if (hdr.length > STORE_DEPTH) begin
                  last_in = LAST_FULL;
               end else if (hdr.length == '0) begin
                  last_in = '0;
               end else begin
                  last_in = IDX_W'(hdr.length - 1'b1);
               end
            end
         end
         RP_READ: begin
            state_in = RP_LOAD;
         end
         RP_LOAD: begin
            if (load) begin
               if (idx_ff == last_ff) begin
                  state_in = RP_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = RP_READ;
               end
            end
         end
         default: begin
            state_in = RP_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= RP_IDLE;
         idx_ff       <= '0;
         last_ff      <= '0;
         empty_ff     <= 1'b0;
         trunc_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         last_ff      <= last_in;
         empty_ff     <= empty_in;
         trunc_ff     <= trunc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rd_en     = (state_ff == RP_READ);
   assign rd_addr   = idx_ff[AW-1:0];
   assign busy      = (state_ff != RP_IDLE);
   assign rsp       = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== rtl/core/marker_length_frame_deframer_top.sv =====
// Parsing: one byte per cycle on req while no replay is running; header bytes are latched
//   in registers; payload bytes up to MAX_PAYLOAD go into the payload buffer (one write port).
// Replay: after the end marker transfer, each result takes a buffer read, then an output
//   load; req is held off until the last result of the frame is loaded, later on rsp stalls.
//   An empty frame gives one result.
// Reset (synchronous): hunt, flag/id = 1, length = 0, markers 0x00/0xFF, buffer uncleared.
`default_nettype none

module marker_length_frame_deframer_top import mlfd_pkg::*; #(
   parameter int MAX_PAYLOAD = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,

   // configuration write channel
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [BYTE_W-1:0]    csr_wdata,

   // received bytes
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [BYTE_W-1:0]    req_rx_byte,

   // replayed frame results
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic      [BYTE_W-1:0]    rsp_frame_flag,
   output logic      [BYTE_W-1:0]    rsp_frame_id,
   output logic      [BYTE_W-1:0]    rsp_payload_length,
   output logic      [IDX_W-1:0]     rsp_byte_index,
   output logic      [BYTE_W-1:0]    rsp_payload_byte,
   output logic                      rsp_empty_payload,
   output logic                      rsp_truncated,
   output logic                      rsp_last
);

   // buffer address width; at least one bit even for a single-entry buffer
   localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

   logic [BYTE_W-1:0] start_marker_ff, start_marker_in;
   logic [BYTE_W-1:0] end_marker_ff, end_marker_in;

   frame_hdr_type     hdr;
   logic              req_accept;
   logic              buf_wr_en;
   logic [AW-1:0]     buf_wr_addr;
   logic [BYTE_W-1:0] buf_wr_data;
   logic              buf_rd_en;
   logic [AW-1:0]     buf_rd_addr;
   logic [BYTE_W-1:0] buf_rd_data;
   logic              replay_start;
   logic              replay_busy;
   rsp_item_type      rsp_item;

   // Configuration: always ready, takes effect on the next byte. Drop unknown indexes.
   assign csr_ready = 1'b1;

   always_comb begin
      start_marker_in = start_marker_ff;
      end_marker_in   = end_marker_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == CSR_START_MARKER) begin
            start_marker_in = csr_wdata;
         end else if (csr_index == CSR_END_MARKER) begin
            end_marker_in = csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff <= 8'h00;
         end_marker_ff   <= 8'hFF;
      end else begin
         start_marker_ff <= start_marker_in;
         end_marker_ff   <= end_marker_in;
      end
   end

   // Hold off new bytes while a frame is being replayed out of the buffer; this also keeps
   // buffer writes and replay reads from ever touching the buffer in the same cycle.
   assign req_ready  = !replay_busy;
   assign req_accept = req_valid && req_ready;

   // Header capture and payload store sequencing
   mlfd_parser #(
      .MAX_PAYLOAD (MAX_PAYLOAD),
      .AW          (AW)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_accept),
      .rx_byte      (req_rx_byte),
      .start_marker (start_marker_ff),
      .end_marker   (end_marker_ff),
      .hdr          (hdr),
      .wr_en        (buf_wr_en),
      .wr_addr      (buf_wr_addr),
      .wr_data      (buf_wr_data),
      .replay_start (replay_start)
   );

   // Payload buffer, one write and one registered read port
   mlfd_buffer #(
      .DEPTH (MAX_PAYLOAD),
      .AW    (AW)
   ) u_buffer (
      .clock   (clock),
      .wr_en   (buf_wr_en),
      .wr_addr (buf_wr_addr),
      .wr_data (buf_wr_data),
      .rd_en   (buf_rd_en),
      .rd_addr (buf_rd_addr),
      .rd_data (buf_rd_data)
   );

   // Replay sequencer with the output register
   mlfd_replay #(
      .MAX_PAYLOAD (MAX_PAYLOAD),
      .AW          (AW)
   ) u_replay (
      .clock     (clock),
      .reset     (reset),
      .start     (replay_start),
      .hdr       (hdr),
      .rd_data   (buf_rd_data),
      .rd_en     (buf_rd_en),
      .rd_addr   (buf_rd_addr),
      .busy      (replay_busy),
      .rsp       (rsp_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready)
   );

   assign rsp_frame_flag     = rsp_item.frame_flag;
   assign rsp_frame_id       = rsp_item.frame_id;
   assign rsp_payload_length = rsp_item.payload_length;
   assign rsp_byte_index     = rsp_item.byte_index;
   assign rsp_payload_byte   = rsp_item.payload_byte;
   assign rsp_empty_payload  = rsp_item.empty_payload;
   assign rsp_truncated      = rsp_item.truncated;
   assign rsp_last           = rsp_item.last;

   // An empty frame gives exactly one zeroed, non-truncated result
   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_payload |->
         rsp_last && !rsp_truncated && (rsp_byte_index == '0) && (rsp_payload_byte == '0))
      else $error("empty frame result malformed");

   // The buffer is never written while a replay reads it
   a_no_write_in_replay: assert property (@(posedge clock) disable iff (reset)
      buf_wr_en |-> !replay_busy)
      else $error("buffer write during replay");

   // A replay ends only by loading the last result of the frame
   a_replay_ends_last: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $fell(replay_busy) |-> rsp_valid && rsp_last)
      else $error("replay ended without last result");

endmodule

`default_nettype wire
